// File: rtl/smcsr_pkg.sv
// Shared types and constants for the sparse matrix compressed-row store.
package smcsr_pkg;

   localparam int MAX_ROWS_DEF = 256;
   localparam int MAX_COLS_DEF = 256;
   localparam int CAPACITY_DEF = 1024;

   localparam int CFG_W = 9;
   localparam int VAL_W = 32;
   localparam int COORD_W = 8;
   localparam int REQ_W = 56;
   localparam int RSP_W = 40;

   localparam logic [1:0] CMD_READ = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_ACCUM = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic clr_wr;
      logic check;
      logic rs_rd_row;
      logic lo_load;
      logic bounds_load;
      logic search_rd;
      logic cmp_step;
      logic decide;
      logic shift_rd;
      logic shift_wr;
      logic ins_wr;
      logic ptr_rd;
      logic ptr_wr;
      logic emit;
   } smcsr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic range_bad;
      logic search_open;
      logic col_eq;
      logic done_path;
      logic shift_more;
      logic ptr_last;
      logic out_busy;
   } smcsr_stat_type;

endpackage

// File: rtl/smcsr_ctrl.sv
// Sequencing state machine for the compressed-row store.
module smcsr_ctrl import smcsr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  smcsr_stat_type stat,
   output smcsr_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_CHECK, S_LO, S_HI, S_SEARCH, S_CMP, S_DECIDE,
      S_SHIFT_RD, S_SHIFT_WR, S_PTR_RD, S_PTR_WR, S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.ptr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (stat.range_bad) state_in = S_DONE;
            else begin
               cmd.rs_rd_row = 1'b1;
               state_in = S_LO;
            end
         end
         S_LO: begin
            cmd.lo_load = 1'b1;
            state_in = S_HI;
         end
         S_HI: begin
            cmd.bounds_load = 1'b1;
            state_in = S_SEARCH;
         end
         S_SEARCH: begin
            if (stat.search_open) begin
               cmd.search_rd = 1'b1;
               state_in = S_CMP;
            end else state_in = S_DECIDE;
         end
         S_CMP: begin
            cmd.cmp_step = 1'b1;
            state_in = stat.col_eq ? S_DECIDE : S_SEARCH;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = stat.done_path ? S_DONE : S_SHIFT_RD;
         end
         S_SHIFT_RD: begin
            if (stat.shift_more) begin
               cmd.shift_rd = 1'b1;
               state_in = S_SHIFT_WR;
            end else begin
               cmd.ins_wr = 1'b1;
               state_in = S_PTR_RD;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in = S_SHIFT_RD;
         end
         S_PTR_RD: begin
            cmd.ptr_rd = 1'b1;
            state_in = S_PTR_WR;
         end
         S_PTR_WR: begin
            cmd.ptr_wr = 1'b1;
            state_in = stat.ptr_last ? S_DONE : S_PTR_RD;
         end
         S_DONE: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> state_ff == S_IDLE)
      else $error("emit did not return to idle");
   assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> !cmd.clr_wr && state_ff == S_IDLE)
      else $error("transaction taken outside idle");
   assert property (@(posedge clock) disable iff (reset)
      cmd.ptr_wr |-> $past(cmd.ptr_rd))
      else $error("pointer write without read");

endmodule

// File: rtl/smcsr_dp.sv
// Datapath: row pointer and entry memories, search, shift and result registers.
module smcsr_dp import smcsr_pkg::*; #(
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [REQ_W-1:0]   req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [CFG_W-1:0]   csr_wdata,
   input  smcsr_cmd_type      cmd,
   output smcsr_stat_type     stat
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int RW = $clog2(MAX_ROWS + 1);

   logic [CFG_W-1:0] rows_ff, cols_ff;
   logic [1:0] op_ff;
   logic [COORD_W-1:0] row_ff, col_ff;
   logic signed [VAL_W-1:0] val_ff;

   logic [CW-1:0] rs_mem [MAX_ROWS+1];
   logic [CW-1:0] rs_rd_ff;
   logic [RW-1:0] rs_raddr, ptr_ff, row_idx, row_nxt;

   logic [COORD_W-1:0] col_mem [CAPACITY];
   logic signed [VAL_W-1:0] ev_mem [CAPACITY];
   logic [COORD_W-1:0] col_rd_ff;
   logic signed [VAL_W-1:0] ev_rd_ff;
   logic [AW-1:0] ent_raddr;

   logic [CW-1:0] lo_ff, hi_ff, mid_ff, i_ff, cnt_ff, mid_c, hi_c;
   logic [CW:0] mid_sum;
   logic found_ff;

   logic signed [VAL_W-1:0] pend_val_ff, out_val_ff, new_val;
   logic pend_hit_ff, out_hit_ff, out_valid_ff;
   logic [1:0] pend_st_ff, out_st_ff;
   logic [VAL_W:0] sum;
   logic is_read, full;

   assign row_idx = RW'(row_ff);
   assign row_nxt = RW'({1'b0, row_ff} + 9'd1);
   assign is_read = (op_ff != CMD_WRITE) && (op_ff != CMD_ACCUM);
   assign full = cnt_ff >= CW'(CAPACITY);
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_c = mid_sum[CW:1];
   assign hi_c = (rs_rd_ff < cnt_ff) ? rs_rd_ff : cnt_ff;

   // saturating Q16.16 add
   assign sum = {ev_rd_ff[VAL_W-1], ev_rd_ff} + {val_ff[VAL_W-1], val_ff};
   always_comb begin
      if (op_ff != CMD_ACCUM) new_val = val_ff;
      else if (sum[VAL_W] != sum[VAL_W-1])
         new_val = sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      else new_val = sum[VAL_W-1:0];
   end

   assign stat.range_bad = ({24'd0, row_ff} >= 32'(MAX_ROWS)) ||
                           ({1'b0, row_ff} >= rows_ff) ||
                           ({24'd0, col_ff} >= 32'(MAX_COLS)) ||
                           ({1'b0, col_ff} >= cols_ff);
   assign stat.search_open = lo_ff < hi_ff;
   assign stat.col_eq = col_rd_ff == col_ff;
   assign stat.done_path = is_read || found_ff || full;
   assign stat.shift_more = i_ff > lo_ff;
   assign stat.ptr_last = ptr_ff == RW'(MAX_ROWS);
   assign stat.out_busy = out_valid_ff && !rsp_tready;

   always_comb begin
      if (cmd.rs_rd_row) rs_raddr = row_idx;
      else if (cmd.lo_load) rs_raddr = row_nxt;
      else rs_raddr = ptr_ff;
   end
   assign ent_raddr = cmd.shift_rd ? AW'(i_ff - CW'(1)) : AW'(mid_c);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CFG_W'(256);
         cols_ff <= CFG_W'(256);
      end else if (csr_we) begin
         if (csr_index == REG_ROWS) rows_ff <= csr_wdata;
         else cols_ff <= csr_wdata;
      end
   end

   // row pointer memory
   always_ff @(posedge clock) begin
      rs_rd_ff <= rs_mem[rs_raddr];
      if (cmd.clr_wr) rs_mem[ptr_ff] <= '0;
      else if (cmd.ptr_wr) rs_mem[ptr_ff] <= rs_rd_ff + CW'(1);
   end

   // entry memories
   always_ff @(posedge clock) begin
      if (cmd.search_rd || cmd.shift_rd) begin
         col_rd_ff <= col_mem[ent_raddr];
         ev_rd_ff <= ev_mem[ent_raddr];
      end
      if (cmd.ins_wr) begin
         col_mem[AW'(lo_ff)] <= col_ff;
         ev_mem[AW'(lo_ff)] <= val_ff;
      end else if (cmd.shift_wr) begin
         col_mem[AW'(i_ff)] <= col_rd_ff;
         ev_mem[AW'(i_ff)] <= ev_rd_ff;
      end else if (cmd.decide && found_ff && !is_read) begin
         ev_mem[AW'(mid_ff)] <= new_val;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff <= req_tdata[1:0];
         row_ff <= req_tdata[9:2];
         col_ff <= req_tdata[17:10];
         val_ff <= req_tdata[49:18];
      end
      if (cmd.lo_load) lo_ff <= rs_rd_ff;
      if (cmd.bounds_load) begin
         hi_ff <= hi_c;
         if (lo_ff > hi_c) lo_ff <= hi_c;
      end
      if (cmd.search_rd) mid_ff <= mid_c;
      if (cmd.cmp_step && !stat.col_eq) begin
         if (col_rd_ff < col_ff) lo_ff <= mid_ff + CW'(1);
         else hi_ff <= mid_ff;
      end
      if (cmd.decide) i_ff <= cnt_ff;
      if (cmd.shift_wr) i_ff <= i_ff - CW'(1);
      if (cmd.check) begin
         pend_val_ff <= '0;
         pend_hit_ff <= 1'b0;
         pend_st_ff <= ST_RANGE;
      end
      if (cmd.decide) begin
         pend_hit_ff <= found_ff;
         pend_st_ff <= (!is_read && !found_ff && full) ? ST_FULL : ST_OK;
         priority if (is_read) pend_val_ff <= found_ff ? ev_rd_ff : '0;
         else if (found_ff) pend_val_ff <= new_val;
         else if (full) pend_val_ff <= '0;
         else pend_val_ff <= val_ff;
      end
      if (cmd.emit) begin
         out_val_ff <= pend_val_ff;
         out_hit_ff <= pend_hit_ff;
         out_st_ff <= pend_st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         cnt_ff <= '0;
         found_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_wr || (cmd.ptr_wr && !stat.ptr_last)) ptr_ff <= ptr_ff + RW'(1);
         else if (cmd.ins_wr) ptr_ff <= row_nxt;
         if (cmd.ptr_wr && stat.ptr_last) cnt_ff <= cnt_ff + CW'(1);
         if (cmd.take) found_ff <= 1'b0;
         else if (cmd.cmp_step && stat.col_eq) found_ff <= 1'b1;
         if (cmd.emit) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {5'd0, out_st_ff, out_hit_ff, out_val_ff};

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");
   assert property (@(posedge clock) disable iff (reset)
      (cmd.ptr_wr && stat.ptr_last) |=> cnt_ff == $past(cnt_ff) + CW'(1))
      else $error("entry count not bumped after insert");
   assert property (@(posedge clock) disable iff (reset)
      cmd.shift_rd |-> !found_ff && !full)
      else $error("shift started on hit or full store");
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(out_valid_ff && !rsp_tready))
      else $error("result overwritten while pending");

endmodule

// File: rtl/sparse_matrix_csr_store_unit.sv
// Top level of the compressed-row sparse matrix store.
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  command, row, col, value
//  rsp      out        rsp_tvalid/rsp_tready  result_value, hit, status
//  csr      in         csr_we                 rows_in_use, cols_in_use
//
// Read or hit: a binary search over the row's entries, one registered entry read
// per step. Insert then moves each later entry up by one and bumps every
// following row pointer, each move and each bump a read and then a write.
// After reset a clearing pass zeroes the MAX_ROWS+1 row pointers; req_tready
// stays low meanwhile. One transaction is worked at a time; a
// finished result waits in the output register while the next is accepted.
module sparse_matrix_csr_store_unit import smcsr_pkg::*; #(
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // command[1:0] row[9:2] col[17:10] value[49:18]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // result_value[31:0] hit[32] status[34:33]
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   smcsr_cmd_type  cmd;
   smcsr_stat_type stat;

   smcsr_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .stat(stat), .cmd(cmd)
   );

   smcsr_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .CAPACITY(CAPACITY)) u_dp (
      .clock(clock), .reset(reset), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .cmd(cmd), .stat(stat)
   );

endmodule

// File: tb/tb_sparse_matrix_csr_store_unit.sv
// Self-checking testbench for the compressed-row sparse matrix store.
`timescale 1ns / 100ps

module tb_sparse_matrix_csr_store_unit;
   import smcsr_pkg::*;

   localparam logic [1:0] CMD_UNUSED = CMD_WRITE | CMD_ACCUM;
   localparam int         HOLD_CYCLES = 400;
   localparam int         SETTLE_CYCLES = 3000;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_we;
   logic             csr_index;
   logic [CFG_W-1:0] csr_wdata;

   sparse_matrix_csr_store_unit DUT (.*);

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             hit;
      logic [1:0]       status;
   } outcome_type;

   typedef struct {
      bit               is_cfg;    // row writes both registers instead of a transaction
      logic [1:0]       cmd;
      logic [8:0]       row;       // rows_in_use for config rows
      logic [8:0]       col;       // cols_in_use for config rows
      logic [VAL_W-1:0] value;
      bit               typed;     // expected outcome given in the row
      outcome_type      want;
   } step_type;

   // shadow of the store
   logic [10:0]      row_ptr [0:MAX_ROWS_DEF];
   logic [7:0]       ent_col [0:CAPACITY_DEF-1];
   logic [VAL_W-1:0] ent_val [0:CAPACITY_DEF-1];
   int               ent_cnt;
   logic [8:0]       rows_reg, cols_reg;

   outcome_type pending_q[$];
   int       err_cnt, item_cnt, hit_cnt, ins_cnt, full_cnt, range_cnt;
   bit       quiet, hold_req;
   int       hold_left;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #60_000_000;
      $display("tb_sparse_matrix_csr_store_unit: errors");
      $finish;
   end

   task automatic report(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      err_cnt++;
   endtask

   task automatic predict_store(input logic [1:0] cmd, input logic [7:0] r, c,
                                input logic [VAL_W-1:0] v, output outcome_type o);
      int     lo, hi, mid, i, nr, nc;
      bit     found;
      longint sum;
      o = '{value: '0, hit: 1'b0, status: ST_OK};
      nr = rows_reg > MAX_ROWS_DEF ? MAX_ROWS_DEF : rows_reg;
      nc = cols_reg > MAX_COLS_DEF ? MAX_COLS_DEF : cols_reg;
      if (r >= nr || c >= nc) begin
         o.status = ST_RANGE;
         range_cnt++;
         return;
      end
      lo = row_ptr[r];
      hi = row_ptr[r + 1];
      if (hi > ent_cnt) hi = ent_cnt;
      if (lo > hi) lo = hi;
      found = 1'b0;
      mid = lo;
      while (lo < hi) begin
         mid = (lo + hi) >> 1;
         if (ent_col[mid] == c) begin
            found = 1'b1;
            break;
         end
         if (ent_col[mid] < c) lo = mid + 1;
         else hi = mid;
      end
      if (found) hit_cnt++;
      if (cmd != CMD_WRITE && cmd != CMD_ACCUM) begin
         if (found) begin
            o.value = ent_val[mid];
            o.hit = 1'b1;
         end
         return;
      end
      if (found) begin
         if (cmd == CMD_ACCUM) begin
            sum = longint'($signed(ent_val[mid])) + longint'($signed(v));
            if (sum > 64'sd2147483647) o.value = 32'h7FFF_FFFF;
            else if (sum < -64'sd2147483648) o.value = 32'h8000_0000;
            else o.value = sum[31:0];
         end else begin
            o.value = v;
         end
         ent_val[mid] = o.value;
         o.hit = 1'b1;
         return;
      end
      if (ent_cnt >= CAPACITY_DEF) begin
         o.status = ST_FULL;
         full_cnt++;
         return;
      end
      for (i = ent_cnt; i > lo; i--) begin
         ent_val[i] = ent_val[i - 1];
         ent_col[i] = ent_col[i - 1];
      end
      ent_val[lo] = v;
      ent_col[lo] = c;
      for (i = r + 1; i <= MAX_ROWS_DEF; i++) row_ptr[i] = row_ptr[i] + 11'd1;
      ent_cnt++;
      ins_cnt++;
      o.value = v;
   endtask

   // offer one transaction; returns after it is accepted
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] r, c,
                            input logic [VAL_W-1:0] v, input bit typed,
                            input outcome_type want);
      outcome_type o;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 99) < 6) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_W - 50){1'b0}}, v, c, r, cmd};
      do @(posedge clock); while (!req_tready);
      predict_store(cmd, r, c, v, o);
      item_cnt++;
      if (typed && o != want)
         report($sformatf("directed row (%0d,%0d) cmd %0d: table %h/%0d/%0d, model %h/%0d/%0d",
                          r, c, cmd, want.value, want.hit, want.status,
                          o.value, o.hit, o.status));
      pending_q.push_back(o);
   endtask

   task automatic write_regs(input logic [8:0] nrows, ncols);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= REG_ROWS;
      csr_wdata <= nrows;
      @(negedge clock);
      csr_index <= REG_COLS;
      csr_wdata <= ncols;
      @(negedge clock);
      csr_we <= 1'b0;
      rows_reg = nrows;
      cols_reg = ncols;
   endtask

   task automatic random_item();
      logic [1:0]       cmd;
      logic [7:0]       r, c;
      logic [VAL_W-1:0] v;
      int               k;
      k = $urandom_range(0, 99);
      cmd = k < 35 ? CMD_READ : k < 65 ? CMD_WRITE : k < 95 ? CMD_ACCUM : CMD_UNUSED;
      r = $urandom_range(0, 99) < 80 ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
      c = $urandom_range(0, 99) < 80 ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
      k = $urandom_range(0, 99);
      v = k < 7 ? 32'h7FFF_FFFF : k < 14 ? 32'h8000_0000 : k < 20 ? 32'hFFFF_FFFF : $urandom;
      send_item(cmd, r, c, v, 1'b0, '{default: '0});
   endtask

   // receiver: random backpressure plus a long hold when hold_req is set
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req = 1'b0;
      end
      if (reset) rsp_tready <= 1'b0;
      else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else rsp_tready <= quiet || $urandom_range(0, 99) >= 6;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) report($sformatf("unexpected result %h", rsp_tdata));
         else begin
            outcome_type e;
            e = pending_q.pop_front();
            if (rsp_tdata[31:0] !== e.value)
               report($sformatf("result_value %h, want %h", rsp_tdata[31:0], e.value));
            if (rsp_tdata[32] !== e.hit)
               report($sformatf("hit %b, want %b", rsp_tdata[32], e.hit));
            if (rsp_tdata[34:33] !== e.status)
               report($sformatf("status %0d, want %0d", rsp_tdata[34:33], e.status));
            if (rsp_tdata[RSP_W-1:35] !== '0)
               report($sformatf("pad bits %h not zero", rsp_tdata[RSP_W-1:35]));
         end
      end
   end

   step_type plan[$];

   function automatic step_type mk(bit cfg, logic [1:0] cmd, logic [8:0] r, c,
                                   logic [31:0] v, bit typed, logic [31:0] wv,
                                   logic wh, logic [1:0] ws);
      step_type s;
      s.is_cfg = cfg;
      s.cmd = cmd;
      s.row = r;
      s.col = c;
      s.value = v;
      s.typed = typed;
      s.want = '{value: wv, hit: wh, status: ws};
      return s;
   endfunction

   initial begin
      int i;
      step_type s;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = REG_ROWS;
      csr_wdata = '0;
      quiet = 1'b0;
      hold_req = 1'b0;
      hold_left = 0;
      for (i = 0; i <= MAX_ROWS_DEF; i++) row_ptr[i] = '0;
      for (i = 0; i < CAPACITY_DEF; i++) begin
         ent_col[i] = '0;
         ent_val[i] = '0;
      end
      ent_cnt = 0;
      rows_reg = 9'd256;
      cols_reg = 9'd256;

      // directed rows
      plan.push_back(mk(0, CMD_READ,   0,   0, 32'h1234_5678, 1, 0, 0, ST_OK));
      plan.push_back(mk(0, CMD_WRITE,  0,   0, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 0, ST_OK));
      plan.push_back(mk(0, CMD_ACCUM,  0,   0, 32'h0000_0001, 1, 32'h7FFF_FFFF, 1, ST_OK));
      plan.push_back(mk(0, CMD_WRITE, 255, 255, 32'h8000_0000, 1, 32'h8000_0000, 0, ST_OK));
      plan.push_back(mk(0, CMD_ACCUM, 255, 255, 32'hFFFF_FFFF, 1, 32'h8000_0000, 1, ST_OK));
      plan.push_back(mk(0, CMD_READ,  255, 255, 32'h0,         1, 32'h8000_0000, 1, ST_OK));
      plan.push_back(mk(0, CMD_UNUSED,  0,   0, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 1, ST_OK));
      plan.push_back(mk(0, CMD_WRITE,   5,   3, 32'h0003_0000, 0, 0, 0, ST_OK));
      plan.push_back(mk(0, CMD_WRITE,   5,   1, 32'h0001_8000, 0, 0, 0, ST_OK));
      plan.push_back(mk(0, CMD_ACCUM,   5,   2, 32'hFFFE_0000, 0, 0, 0, ST_OK));
      plan.push_back(mk(0, CMD_ACCUM,   5,   3, 32'h0000_0001, 0, 0, 0, ST_OK));
      plan.push_back(mk(0, CMD_READ,    5,   2, 32'h0,         0, 0, 0, ST_OK));
      plan.push_back(mk(0, CMD_READ,    4,   2, 32'h0,         1, 0, 0, ST_OK));
      plan.push_back(mk(1, CMD_READ,    1,   1, 32'h0,         0, 0, 0, ST_OK));
      plan.push_back(mk(0, CMD_WRITE,   1,   0, 32'h5,         1, 0, 0, ST_RANGE));
      plan.push_back(mk(0, CMD_ACCUM,   0,   1, 32'h5,         1, 0, 0, ST_RANGE));
      plan.push_back(mk(0, CMD_READ,    0,   0, 32'h0,         1, 32'h7FFF_FFFF, 1, ST_OK));
      plan.push_back(mk(1, CMD_READ,    0, 256, 32'h0,         0, 0, 0, ST_OK));
      plan.push_back(mk(0, CMD_READ,    0,   0, 32'h0,         1, 0, 0, ST_RANGE));
      plan.push_back(mk(1, CMD_READ,  511, 511, 32'h0,         0, 0, 0, ST_OK));
      plan.push_back(mk(0, CMD_READ,  255, 255, 32'h0,         1, 32'h8000_0000, 1, ST_OK));
      plan.push_back(mk(0, CMD_WRITE, 255,   0, 32'h0000_0000, 0, 0, 0, ST_OK));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[k]) begin
         s = plan[k];
         if (s.is_cfg) write_regs(s.row, s.col);
         else send_item(s.cmd, s.row[7:0], s.col[7:0], s.value, s.typed, s.want);
      end

      // random part in three register settings
      write_regs(9'd256, 9'd256);
      for (i = 0; i < 180; i++) begin
         quiet = i >= 60 && i < 140;
         random_item();
      end
      quiet = 1'b0;
      write_regs(9'($urandom_range(2, 200)), 9'($urandom_range(2, 40)));
      for (i = 0; i < 90; i++) random_item();
      write_regs(9'd256, 9'd256);
      hold_req = 1'b1;
      for (i = 0; i < 160; i++) random_item();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d transactions: %0d hits, %0d inserts, %0d refused as full, %0d out of range",
               item_cnt, hit_cnt, ins_cnt, full_cnt, range_cnt);
      $display("store held %0d entries at the end; %0d mismatches", ent_cnt, err_cnt);
      if (err_cnt == 0) $display("tb_sparse_matrix_csr_store_unit: clean");
      else $display("tb_sparse_matrix_csr_store_unit: errors");
      $finish;
   end

endmodule
